>>> hw/rtl/emrc_pkg.sv
// Shared types and constants for the encoder motor ramp controller.
package emrc_pkg;

   localparam int MAX_OVERSHOOT    = 8;
   localparam int VELOCITY_SCALE   = 4096;
   localparam int RINGING_VELOCITY = 99;
   localparam int MIN_DOWN_EDGES   = 3;
   localparam int SHORT_MOVE       = 6;
   localparam int UP_STEP_MIN      = 2;
   localparam int DIV_QW           = 16;

   localparam logic [7:0]  RST_MIN_SPEED     = 8'd40;
   localparam logic [7:0]  RST_STOP_SPEED    = 8'd30;
   localparam logic [7:0]  RST_MAX_SPEED     = 8'd255;
   localparam logic [4:0]  RST_SPEED_COMP    = 5'd0;
   localparam logic [7:0]  RST_RAMP_INTERVAL = 8'd20;
   localparam logic [7:0]  RST_RAMP_UP_STEP  = 8'd4;
   localparam logic [7:0]  RST_EDGE_MASK     = 8'd4;
   localparam logic [15:0] RST_STALL_TIMEOUT = 16'd500;

   typedef enum logic [1:0] {PH_STOP, PH_UP, PH_FULL, PH_DOWN} phase_type;
   typedef enum logic [1:0] {DRV_FWD, DRV_BACK, DRV_BRAKE, DRV_RELEASE} drive_type;
   typedef enum logic [1:0] {MODE_TICK, MODE_EDGE, MODE_GO, MODE_STOP} mode_type;

   typedef enum logic [2:0] {
      REG_MIN_SPEED, REG_STOP_SPEED, REG_MAX_SPEED, REG_SPEED_COMP,
      REG_RAMP_INTERVAL, REG_RAMP_UP_STEP, REG_EDGE_MASK, REG_STALL_TIMEOUT
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  min_speed;
      logic [7:0]  stop_speed;
      logic [7:0]  max_speed;
      logic [4:0]  speed_comp;
      logic [7:0]  ramp_interval;
      logic [7:0]  ramp_up_step;
      logic [7:0]  edge_mask;
      logic [15:0] stall_timeout;
   } cfg_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_NOW, CMD_PHASE, CMD_FULLDOWN, CMD_DOWNAPPLY,
      CMD_STALL, CMD_EDGE, CMD_EDGEVEL, CMD_GO, CMD_STOP
   } cmd_type;

   typedef struct packed {
      logic div_started;
      logic div_done;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NOW, ST_PHASE, ST_FULLDOWN, ST_DIVDOWN, ST_DOWNAPPLY,
      ST_STALL, ST_EDGE, ST_DIVVEL, ST_EDGEVEL, ST_GO, ST_STOP, ST_DONE
   } state_type;

endpackage

>>> hw/rtl/encoder_motor_ramp_controller.sv
// Top level: register file, sequencer and motion datapath.
//
//  channel | direction | handshake                     | payload
//  req     | in        | req_tvalid / req_tready       | tuser mode, tdata go_distance
//  rsp     | out       | rsp_tvalid / rsp_tready       | tdata speed, mode, phase, counts
//  csr     | in        | csr_psel, csr_penable, pready | 8 registers at 4*i
//
// A tick steps through the NOW, PHASE, FULLDOWN and STALL states, waiting on
// the shared restoring divider when ramp-down entry divides; an encoder edge
// waits on it for the velocity division. A stop request or move command runs
// a single state. The next item is taken once the result is taken.
// Synchronous reset returns the motor to stopped and released, with the
// register defaults loaded.
module encoder_motor_ramp_controller #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic signed [15:0] req_tdata,   // [15:0] go_distance
   input  logic [1:0]         req_tuser,   // [1:0] mode
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [55:0]        rsp_tdata,   // [7:0] drive_speed, [9:8] drive_mode,
                                           // [11:10] phase, [27:12] travelled,
                                           // [43:28] wheel_velocity, [51:44] arrival_speed
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import emrc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;
   cmd_type       cmd;
   stat_type      stat;
   logic [7:0]    drive_speed;
   logic [1:0]    drive_mode;
   logic [1:0]    phase;
   logic [15:0]   travelled;
   logic [15:0]   wheel_velocity;
   logic [7:0]    arrival_speed;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MIN_SPEED:     cfg_in.min_speed     = csr_pwdata[7:0];
            REG_STOP_SPEED:    cfg_in.stop_speed    = csr_pwdata[7:0];
            REG_MAX_SPEED:     cfg_in.max_speed     = csr_pwdata[7:0];
            REG_SPEED_COMP:    cfg_in.speed_comp    = csr_pwdata[4:0];
            REG_RAMP_INTERVAL: cfg_in.ramp_interval = csr_pwdata[7:0];
            REG_RAMP_UP_STEP:  cfg_in.ramp_up_step  = csr_pwdata[7:0];
            REG_EDGE_MASK:     cfg_in.edge_mask     = csr_pwdata[7:0];
            REG_STALL_TIMEOUT: cfg_in.stall_timeout = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MIN_SPEED:     csr_prdata = 32'(cfg_ff.min_speed);
         REG_STOP_SPEED:    csr_prdata = 32'(cfg_ff.stop_speed);
         REG_MAX_SPEED:     csr_prdata = 32'(cfg_ff.max_speed);
         REG_SPEED_COMP:    csr_prdata = 32'(cfg_ff.speed_comp);
         REG_RAMP_INTERVAL: csr_prdata = 32'(cfg_ff.ramp_interval);
         REG_RAMP_UP_STEP:  csr_prdata = 32'(cfg_ff.ramp_up_step);
         REG_EDGE_MASK:     csr_prdata = 32'(cfg_ff.edge_mask);
         REG_STALL_TIMEOUT: csr_prdata = 32'(cfg_ff.stall_timeout);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_speed     <= RST_MIN_SPEED;
         cfg_ff.stop_speed    <= RST_STOP_SPEED;
         cfg_ff.max_speed     <= RST_MAX_SPEED;
         cfg_ff.speed_comp    <= RST_SPEED_COMP;
         cfg_ff.ramp_interval <= RST_RAMP_INTERVAL;
         cfg_ff.ramp_up_step  <= RST_RAMP_UP_STEP;
         cfg_ff.edge_mask     <= RST_EDGE_MASK;
         cfg_ff.stall_timeout <= RST_STALL_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   emrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   emrc_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .go_distance    (req_tdata),
      .stat           (stat),
      .drive_speed    (drive_speed),
      .drive_mode     (drive_mode),
      .phase          (phase),
      .travelled      (travelled),
      .wheel_velocity (wheel_velocity),
      .arrival_speed  (arrival_speed)
   );

   assign rsp_tdata = {4'd0, arrival_speed, wheel_velocity, travelled,
                       phase, drive_mode, drive_speed};

endmodule

>>> hw/rtl/emrc_div.sv
// Restoring divider, one quotient bit per cycle.
module emrc_div #(
   parameter int DW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [emrc_pkg::DIV_QW-1:0]    dividend,
   input  logic [DW-1:0]                  divisor,
   output logic                           done,
   output logic [emrc_pkg::DIV_QW-1:0]    quotient
);
   import emrc_pkg::*;

   localparam int CNTW = $clog2(DIV_QW);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [DIV_QW-1:0]   q_ff, q_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       div_ff, div_in;
   logic [DW:0]         rem_sh;
   logic [DW:0]         rem_sub;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[DIV_QW-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DIV_QW - 1);
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_QW-2:0], ge};
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> hw/rtl/emrc_datapath.sv
// Motion state registers and the arithmetic for each controller command.
module emrc_datapath #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  emrc_pkg::cfg_type    cfg,
   input  emrc_pkg::cmd_type    cmd,
   input  logic signed [15:0]   go_distance,
   output emrc_pkg::stat_type   stat,
   output logic [7:0]           drive_speed,
   output logic [1:0]           drive_mode,
   output logic [1:0]           phase,
   output logic [15:0]          travelled,
   output logic [15:0]          wheel_velocity,
   output logic [7:0]           arrival_speed
);
   import emrc_pkg::*;

   localparam int CW = COUNT_WIDTH;
   localparam int DW = (CW > 16) ? CW : 16;
   localparam int SW = DW + 3;
   localparam logic [CW-1:0] CMAX = '1;
   localparam logic signed [SW-1:0] CMAX_W = $signed(SW'(CMAX));
   localparam logic signed [SW-1:0] OVERSHOOT_W = SW'(MAX_OVERSHOOT);

   function automatic logic [CW-1:0] sat_count(input logic signed [SW-1:0] v);
      logic [CW-1:0] r;
      if (v < 0) r = '0;
      else if (v > CMAX_W) r = CMAX;
      else r = v[CW-1:0];
      return r;
   endfunction

   phase_type          phase_ff, phase_in;
   drive_type          drive_ff, drive_in;
   logic [7:0]         cur_ff, cur_in;
   logic [7:0]         ceil_ff, ceil_in;
   logic [CW-1:0]      target_ff, target_in;
   logic [CW-1:0]      edge_ff, edge_in;
   logic [CW-1:0]      ncc_ff, ncc_in;
   logic [CW-1:0]      car_ff, car_in;
   logic [CW-1:0]      last_target_ff, last_target_in;
   logic [7:0]         down_ff, down_in;
   logic [7:0]         up_ff, up_in;
   logic [31:0]        now_ff, now_in;
   logic [31:0]        next_ramp_ff, next_ramp_in;
   logic [31:0]        last_edge_ff, last_edge_in;
   logic               reverse_ff, reverse_in;
   logic [15:0]        vel_ff, vel_in;
   logic [7:0]         arrival_ff, arrival_in;
   logic signed [15:0] go_ff, go_in;
   logic               neg_ff, neg_in;

   logic               div_start;
   logic [DIV_QW-1:0]  div_a;
   logic [DW-1:0]      div_b;
   logic               div_done;
   logic [DIV_QW-1:0]  div_q;

   logic               ncc_reached;
   logic [7:0]         up_sum;
   logic [7:0]         rd;
   logic [7:0]         cur_tmp;
   logic [7:0]         dstep;
   logic [8:0]         num_mag;
   logic [15:0]        dt;
   logic [16:0]        dmag;
   logic signed [SW-1:0] dext;
   logic signed [SW-1:0] delta;
   logic signed [SW-1:0] delta_mag;
   logic [CW-1:0]      tgt;

   emrc_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      phase_in       = phase_ff;
      drive_in       = drive_ff;
      cur_in         = cur_ff;
      ceil_in        = ceil_ff;
      target_in      = target_ff;
      edge_in        = edge_ff;
      ncc_in         = ncc_ff;
      car_in         = car_ff;
      last_target_in = last_target_ff;
      down_in        = down_ff;
      up_in          = up_ff;
      now_in         = now_ff;
      next_ramp_in   = next_ramp_ff;
      last_edge_in   = last_edge_ff;
      reverse_in     = reverse_ff;
      vel_in         = vel_ff;
      arrival_in     = arrival_ff;
      go_in          = go_ff;
      neg_in         = neg_ff;
      div_start      = 1'b0;
      div_a          = '0;
      div_b          = '0;
      ncc_reached    = edge_ff >= ncc_ff;
      up_sum         = cur_ff + up_ff;
      rd             = edge_ff[7:0];
      cur_tmp        = cur_ff;
      num_mag        = (cur_ff < cfg.stop_speed) ? {cfg.stop_speed - cur_ff, 1'b0}
                                                 : {cur_ff - cfg.stop_speed, 1'b0};
      dt             = now_ff[15:0] - last_edge_ff[15:0];
      dmag           = go_ff[15] ? (17'd0 - {1'b1, go_ff}) : {1'b0, go_ff};
      dext           = $signed(SW'(dmag));
      delta          = $signed(SW'(edge_ff)) - $signed(SW'(last_target_ff));
      delta_mag      = (delta < 0) ? -delta : delta;
      tgt            = target_ff;
      // negative numerator: truncated quotient plus one is one only when zero
      if (neg_ff) dstep = (div_q == '0) ? 8'd1 : 8'd0;
      else if (div_q >= DIV_QW'(255)) dstep = 8'd255;
      else dstep = div_q[7:0] + 8'd1;

      case (cmd)
         CMD_LOAD: go_in = go_distance;
         CMD_NOW:  now_in = now_ff + 32'd1;
         CMD_PHASE: begin
            case (phase_ff)
               PH_STOP: begin
                  if (target_ff != '0) begin
                     phase_in     = PH_UP;
                     drive_in     = reverse_ff ? DRV_BACK : DRV_FWD;
                     next_ramp_in = now_ff + 32'(cfg.ramp_interval);
                     cur_in       = cfg.min_speed;
                     ncc_in       = target_ff >> 1;
                     last_edge_in = now_ff - 32'(cfg.edge_mask) - 32'd1;
                     up_in        = (cfg.ramp_up_step < 8'(UP_STEP_MIN))
                                    ? 8'(UP_STEP_MIN) : cfg.ramp_up_step;
                  end
               end
               PH_UP: begin
                  if (now_ff >= next_ramp_ff) begin
                     next_ramp_in = next_ramp_ff + 32'(cfg.ramp_interval);
                     // clip on overshoot of the ceiling or 8-bit wrap
                     if (up_sum > ceil_ff || up_sum <= up_ff) up_sum = ceil_ff;
                     cur_in = up_sum;
                     if (up_sum == ceil_ff || ncc_reached) begin
                        phase_in = PH_FULL;
                        car_in   = edge_ff;
                        if (rd < 8'(MIN_DOWN_EDGES) && target_ff > CW'(SHORT_MOVE))
                           rd = 8'(MIN_DOWN_EDGES);
                        ncc_in = sat_count($signed(SW'(target_ff)) - $signed(SW'(rd)));
                     end
                  end
               end
               default: ;
            endcase
         end
         CMD_FULLDOWN: begin
            if (phase_ff == PH_FULL) begin
               if (ncc_reached) begin
                  ncc_in   = ncc_ff + 1'b1;
                  phase_in = PH_DOWN;
                  if (target_ff <= edge_ff) begin
                     down_in = '0;
                     cur_in  = cfg.stop_speed;
                  end else begin
                     div_start = 1'b1;
                     neg_in    = cur_ff < cfg.stop_speed;
                     div_a     = DIV_QW'(num_mag);
                     div_b     = DW'(target_ff - edge_ff);
                  end
               end
            end else if (phase_ff == PH_DOWN) begin
               if (ncc_reached) begin
                  ncc_in  = ncc_ff + 1'b1;
                  cur_tmp = (cur_ff > down_ff) ? cur_ff - down_ff : cfg.stop_speed;
                  if (cur_tmp < cfg.stop_speed) cur_tmp = cfg.stop_speed;
               end
               cur_in = cur_tmp;
               if (edge_ff >= target_ff) begin
                  arrival_in = cur_tmp;
                  cur_in     = '0;
                  phase_in   = PH_STOP;
                  target_in  = '0;
                  drive_in   = DRV_BRAKE;
               end
            end
         end
         CMD_DOWNAPPLY: begin
            down_in = dstep;
            cur_in  = (cur_ff > dstep) ? cur_ff - dstep : cfg.stop_speed;
         end
         CMD_STALL: begin
            if (phase_ff != PH_STOP && now_ff > last_edge_ff + 32'(cfg.stall_timeout)) begin
               arrival_in = cur_ff;
               cur_in     = '0;
               phase_in   = PH_STOP;
               target_in  = '0;
               drive_in   = DRV_BRAKE;
            end
         end
         CMD_EDGE: begin
            if (dt <= 16'(cfg.edge_mask)) begin
               vel_in = 16'(RINGING_VELOCITY);
            end else begin
               last_edge_in = now_ff;
               edge_in      = edge_ff + 1'b1;
               div_start    = 1'b1;
               div_a        = DIV_QW'(VELOCITY_SCALE);
               div_b        = DW'(dt);
            end
         end
         CMD_EDGEVEL: vel_in = 16'(div_q);
         CMD_GO: begin
            if (go_ff > 16'sd0) reverse_in = 1'b0;
            else if (go_ff < 16'sd0) reverse_in = 1'b1;
            if (phase_ff == PH_STOP) begin
               ceil_in = (cfg.max_speed > 8'(cfg.speed_comp))
                         ? cfg.max_speed - 8'(cfg.speed_comp) : 8'd0;
               // take the last move's overshoot off the new distance
               if (delta_mag <= OVERSHOOT_W && dext >= delta) tgt = sat_count(dext - delta);
               else tgt = sat_count(dext);
               edge_in = '0;
            end else begin
               tgt    = sat_count($signed(SW'(target_ff)) + dext);
               ncc_in = sat_count($signed(SW'(ncc_ff)) + dext);
            end
            target_in      = tgt;
            last_target_in = tgt;
         end
         CMD_STOP: begin
            if (phase_ff != PH_STOP) begin
               ncc_in    = edge_ff;
               target_in = sat_count($signed(SW'(edge_ff)) + $signed(SW'(car_ff)));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STOP;
         drive_ff       <= DRV_RELEASE;
         cur_ff         <= '0;
         ceil_ff        <= '0;
         target_ff      <= '0;
         edge_ff        <= '0;
         ncc_ff         <= '0;
         car_ff         <= '0;
         last_target_ff <= '0;
         down_ff        <= '0;
         up_ff          <= '0;
         now_ff         <= '0;
         next_ramp_ff   <= '0;
         last_edge_ff   <= '0;
         reverse_ff     <= 1'b0;
         vel_ff         <= '0;
         arrival_ff     <= '0;
      end else begin
         phase_ff       <= phase_in;
         drive_ff       <= drive_in;
         cur_ff         <= cur_in;
         ceil_ff        <= ceil_in;
         target_ff      <= target_in;
         edge_ff        <= edge_in;
         ncc_ff         <= ncc_in;
         car_ff         <= car_in;
         last_target_ff <= last_target_in;
         down_ff        <= down_in;
         up_ff          <= up_in;
         now_ff         <= now_in;
         next_ramp_ff   <= next_ramp_in;
         last_edge_ff   <= last_edge_in;
         reverse_ff     <= reverse_in;
         vel_ff         <= vel_in;
         arrival_ff     <= arrival_in;
      end
      go_ff  <= go_in;
      neg_ff <= neg_in;
   end

   assign stat.div_started = div_start;
   assign stat.div_done    = div_done;
   assign drive_speed      = cur_ff;
   assign drive_mode       = drive_ff;
   assign phase            = phase_ff;
   assign travelled        = 16'(edge_ff);
   assign wheel_velocity   = vel_ff;
   assign arrival_speed    = arrival_ff;

endmodule

>>> hw/rtl/emrc_ctrl.sv
// Sequencer: steps each event through the datapath commands.
module emrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_mode,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output emrc_pkg::cmd_type    cmd,
   input  emrc_pkg::stat_type   stat
);
   import emrc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_TICK: state_in = ST_NOW;
                  MODE_EDGE: state_in = ST_EDGE;
                  MODE_GO:   state_in = ST_GO;
                  default:   state_in = ST_STOP;
               endcase
            end
         end
         ST_NOW:       state_in = ST_PHASE;
         ST_PHASE:     state_in = ST_FULLDOWN;
         ST_FULLDOWN:  state_in = stat.div_started ? ST_DIVDOWN : ST_STALL;
         ST_DIVDOWN:   if (stat.div_done) state_in = ST_DOWNAPPLY;
         ST_DOWNAPPLY: state_in = ST_STALL;
         ST_STALL:     state_in = ST_DONE;
         ST_EDGE:      state_in = stat.div_started ? ST_DIVVEL : ST_DONE;
         ST_DIVVEL:    if (stat.div_done) state_in = ST_EDGEVEL;
         ST_EDGEVEL:   state_in = ST_DONE;
         ST_GO:        state_in = ST_DONE;
         ST_STOP:      state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = CMD_NONE;
      case (state_ff)
         ST_IDLE:      cmd = accept ? CMD_LOAD : CMD_NONE;
         ST_NOW:       cmd = CMD_NOW;
         ST_PHASE:     cmd = CMD_PHASE;
         ST_FULLDOWN:  cmd = CMD_FULLDOWN;
         ST_DOWNAPPLY: cmd = CMD_DOWNAPPLY;
         ST_STALL:     cmd = CMD_STALL;
         ST_EDGE:      cmd = CMD_EDGE;
         ST_EDGEVEL:   cmd = CMD_EDGEVEL;
         ST_GO:        cmd = CMD_GO;
         ST_STOP:      cmd = CMD_STOP;
         ST_DONE:      rsp_valid_in = 1'b1;
         default:      cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
